// File: hw/rtl/aane_pkg.sv
// Shared types, constants and tables for the ADPCM-A nibble encoder.
package aane_pkg;

    localparam int PredWidth  = 13;
    localparam int IndexWidth = 6;
    localparam int StepWidth  = 11;
    localparam int CodeWidth  = 4;

    localparam logic [IndexWidth-1:0] StepIndexMax = 6'd48;

    typedef logic [PredWidth-1:0]  pred_t;
    typedef logic [IndexWidth-1:0] index_t;
    typedef logic [StepWidth-1:0]  step_t;
    typedef logic [CodeWidth-1:0]  code_t;

    typedef struct packed {
        pred_t  predictor;
        index_t step_index;
    } codec_state_t;

    function automatic step_t step_lookup(input index_t idx);
        step_t s;
        case (idx)
            6'd0:  s = 11'd16;
            6'd1:  s = 11'd17;
            6'd2:  s = 11'd19;
            6'd3:  s = 11'd21;
            6'd4:  s = 11'd23;
            6'd5:  s = 11'd25;
            6'd6:  s = 11'd28;
            6'd7:  s = 11'd31;
            6'd8:  s = 11'd34;
            6'd9:  s = 11'd37;
            6'd10: s = 11'd41;
            6'd11: s = 11'd45;
            6'd12: s = 11'd50;
            6'd13: s = 11'd55;
            6'd14: s = 11'd60;
            6'd15: s = 11'd66;
            6'd16: s = 11'd73;
            6'd17: s = 11'd80;
            6'd18: s = 11'd88;
            6'd19: s = 11'd97;
            6'd20: s = 11'd107;
            6'd21: s = 11'd118;
            6'd22: s = 11'd130;
            6'd23: s = 11'd143;
            6'd24: s = 11'd157;
            6'd25: s = 11'd173;
            6'd26: s = 11'd190;
            6'd27: s = 11'd209;
            6'd28: s = 11'd230;
            6'd29: s = 11'd253;
            6'd30: s = 11'd279;
            6'd31: s = 11'd307;
            6'd32: s = 11'd337;
            6'd33: s = 11'd371;
            6'd34: s = 11'd408;
            6'd35: s = 11'd449;
            6'd36: s = 11'd494;
            6'd37: s = 11'd544;
            6'd38: s = 11'd598;
            6'd39: s = 11'd658;
            6'd40: s = 11'd724;
            6'd41: s = 11'd796;
            6'd42: s = 11'd876;
            6'd43: s = 11'd963;
            6'd44: s = 11'd1060;
            6'd45: s = 11'd1166;
            6'd46: s = 11'd1282;
            6'd47: s = 11'd1411;
            default: s = 11'd1552;
        endcase
        return s;
    endfunction

    function automatic logic signed [4:0] index_move(input logic [2:0] mag);
        logic signed [4:0] mv;
        case (mag)
            3'd4:    mv = 5'sd2;
            3'd5:    mv = 5'sd5;
            3'd6:    mv = 5'sd7;
            3'd7:    mv = 5'sd9;
            default: mv = -5'sd1;
        endcase
        return mv;
    endfunction

endpackage

// File: hw/rtl/aane_step.sv
// One ADPCM-A encode step: code, predictor update and step index update.
module aane_step (
    input  logic [11:0]                sample,
    input  aane_pkg::codec_state_t     state,
    output aane_pkg::code_t            code,
    output aane_pkg::codec_state_t     state_next
);
    import aane_pkg::*;

    step_t              step;
    logic signed [13:0] pred14;
    logic signed [13:0] diff;
    logic [13:0]        abs_d;
    logic [12:0]        mag;
    logic [12:0]        r1;
    logic [12:0]        r2;
    logic               sign;
    logic               b2;
    logic               b1;
    logic               b0;
    logic [2:0]         m;
    logic [14:0]        prod;
    logic [13:0]        delta14;
    logic [13:0]        acc;
    logic signed [4:0]  mv;
    logic signed [6:0]  idx_sum;

    always_comb
    begin
        step   = step_lookup(state.step_index);
        pred14 = {state.predictor[PredWidth-1], state.predictor};
        diff   = {{2{sample[11]}}, sample} - pred14;
        sign   = diff[13];
        abs_d  = sign ? (14'd0 - diff) : diff;
        mag    = abs_d[12:0];

        b2 = mag >= {2'b00, step};
        r1 = b2 ? (mag - {2'b00, step}) : mag;
        b1 = r1 >= {3'b000, step[10:1]};
        r2 = b1 ? (r1 - {3'b000, step[10:1]}) : r1;
        b0 = r2 >= {4'b0000, step[10:2]};

        m    = {b2, b1, b0};
        code = {sign, m};

        prod    = 15'({m, 1'b1}) * 15'(step);
        delta14 = {2'b00, prod[14:3]};
        acc     = sign ? (pred14 - delta14) : (pred14 + delta14);

        // anything outside 0..2047 wraps to the negative half
        state_next.predictor = {|acc[13:11], acc[11:0]};

        mv      = index_move(m);
        idx_sum = $signed({1'b0, state.step_index}) + {{2{mv[4]}}, mv};
        if (idx_sum[6])
            state_next.step_index = '0;
        else if (idx_sum[5:0] > StepIndexMax)
            state_next.step_index = StepIndexMax;
        else
            state_next.step_index = idx_sum[5:0];
    end

endmodule

// File: hw/rtl/adpcm_a_nibble_encoder.sv
// ADPCM-A nibble encoder top level: input register, encode step, byte output register.
// Takes one 16-bit PCM item per cycle while sample_stall is low (top 12 bits used) and emits
// one packed byte for every two items, earlier code in the high nibble. clip_start clears
// predictor, step index and any held code before the item is encoded. An item with clip_end
// that would otherwise be left unpaired is followed by a zero pad sample, which goes through
// the same encode step to complete the byte. The input register and the byte register
// decouple the two channels, so a waiting byte does not stop items that produce none.
module adpcm_a_nibble_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic [15:0] pcm_sample,
    input  logic        clip_start,
    input  logic        clip_end,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  packed_byte
);
    import aane_pkg::*;

    logic         in_valid_reg;
    logic [15:0]  sample_reg;
    logic         start_reg;
    logic         end_reg;
    codec_state_t state_reg;
    codec_state_t state_next;
    code_t        held_reg;
    logic         pending_reg;
    logic         pad_reg;
    logic         out_valid_reg;
    logic [7:0]   byte_reg;

    codec_state_t cur_state;
    logic [11:0]  step_sample;
    code_t        code;
    logic         restart;
    logic         eff_pending;
    logic         out_free;
    logic         fire;
    logic         item_fire;

    aane_step u_step (
        .sample     (step_sample),
        .state      (cur_state),
        .code       (code),
        .state_next (state_next)
    );

    always_comb
    begin
        restart     = !pad_reg && start_reg;
        cur_state   = restart ? '0 : state_reg;
        step_sample = pad_reg ? 12'd0 : sample_reg[15:4];
        eff_pending = pending_reg && !restart;
        out_free    = !out_valid_reg || !byte_stall;
        fire        = (pad_reg || in_valid_reg) && (out_free || !eff_pending);
        item_fire   = fire && !pad_reg;
    end

    assign sample_stall = in_valid_reg && !item_fire;
    assign byte_valid   = out_valid_reg;
    assign packed_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            start_reg     <= 1'b0;
            end_reg       <= 1'b0;
            state_reg     <= '0;
            pending_reg   <= 1'b0;
            pad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!sample_stall)
            begin
                in_valid_reg <= sample_valid;
                if (sample_valid)
                begin
                    start_reg <= clip_start;
                    end_reg   <= clip_end;
                end
            end

            if (fire && eff_pending)
                out_valid_reg <= 1'b1;
            else if (!byte_stall)
                out_valid_reg <= 1'b0;

            if (fire)
            begin
                state_reg <= state_next;
                if (eff_pending)
                begin
                    pending_reg <= 1'b0;
                    pad_reg     <= 1'b0;
                end
                else
                begin
                    pending_reg <= 1'b1;
                    pad_reg     <= end_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!sample_stall && sample_valid)
            sample_reg <= pcm_sample;
        if (fire && eff_pending)
            byte_reg <= {held_reg, code};
        if (fire && !eff_pending)
            held_reg <= code;
    end

endmodule
